@@ rtl/gpx_pkg.sv @@
// shared types and constants of the spi gpio expander register block
// no dependencies; used by gpx_regfile, gpx_tracker and the top level
`default_nettype none

package gpx_pkg;

   // command codes carried in tuser
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_RESET = 1'b1;

   // opcodes
   localparam logic [7:0] OP_WRITE = 8'h40;
   localparam logic [7:0] OP_READ  = 8'h41;

   // register addresses
   localparam logic [7:0] ADDR_DIR_A  = 8'h00;
   localparam logic [7:0] ADDR_DIR_B  = 8'h01;
   localparam logic [7:0] ADDR_POL_A  = 8'h02;
   localparam logic [7:0] ADDR_POL_B  = 8'h03;
   localparam logic [7:0] ADDR_PU_A   = 8'h0c;
   localparam logic [7:0] ADDR_PU_B   = 8'h0d;
   localparam logic [7:0] ADDR_GPIO_A = 8'h12;
   localparam logic [7:0] ADDR_GPIO_B = 8'h13;
   localparam logic [7:0] ADDR_OLAT_A = 8'h14;
   localparam logic [7:0] ADDR_OLAT_B = 8'h15;
   localparam logic [7:0] ADDR_EMPTY  = 8'hff;

   localparam logic [7:0] DIR_RESET = 8'hff;

   typedef enum logic [1:0] {
      PHASE_OPCODE  = 2'd0,
      PHASE_ADDRESS = 2'd1,
      PHASE_DATA    = 2'd2
   } phase_type;

   // result of one item as seen by the output stage
   typedef struct packed {
      logic       use_mem;   // miso comes from the register file read
      logic [7:0] miso;
      logic [7:0] drive_a;
      logic [7:0] drive_b;
      logic [7:0] enable_a;
      logic [7:0] enable_b;
      logic [7:0] pullup_a;
      logic [7:0] pullup_b;
   } rsp_info_type;

   // value of a register after reset
   function automatic logic [7:0] reg_reset_value(input logic [7:0] addr);
      logic [7:0] val;
      val = 8'h00;
      if (addr == ADDR_DIR_A || addr == ADDR_DIR_B) begin
         val = DIR_RESET;
      end
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/gpx_regfile.sv @@
// register file memory: one write and one registered read per cycle
// valid bits give reset values after power-up or a reset event; uses gpx_pkg
`default_nettype none

module gpx_regfile #(
   parameter int REGISTER_COUNT = 22,
   parameter int IDX_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_idx,
   input  wire logic [7:0]       wr_data,
   output logic      [7:0]       rd_data
);

   logic [7:0]                mem [REGISTER_COUNT];
   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [7:0]                rd_ff;
   logic                      rd_valid_ff;
   logic [IDX_W-1:0]          rd_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_idx];
         rd_idx_ff   <= rd_idx;
         rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : gpx_pkg::reg_reset_value(8'(rd_idx_ff));

endmodule

`default_nettype wire

@@ rtl/gpx_tracker.sv @@
// command tracker: phase state machine, pin control shadow registers, drive latch
// issues register file accesses and builds the result of each item; uses gpx_pkg
`default_nettype none

module gpx_tracker #(
   parameter int REGISTER_COUNT = 22,
   parameter int IDX_W = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic                  command,
   input  wire logic [7:0]            spi_byte,
   input  wire logic [7:0]            pin_levels_a,
   input  wire logic [7:0]            pin_levels_b,
   output logic                       rf_clear,
   output logic                       rf_rd_en,
   output logic [IDX_W-1:0]           rf_rd_idx,
   output logic                       rf_wr_en,
   output logic [IDX_W-1:0]           rf_wr_idx,
   output logic [7:0]                 rf_wr_data,
   output gpx_pkg::rsp_info_type      info
);

   localparam logic [7:0] COUNT = 8'(REGISTER_COUNT);

   gpx_pkg::phase_type phase_ff, phase_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   logic [7:0] pol_a_ff, pol_a_in, pol_b_ff, pol_b_in;
   logic [7:0] pu_a_ff, pu_a_in, pu_b_ff, pu_b_in;
   logic [7:0] drv_a_ff, drv_a_in, drv_b_ff, drv_b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= gpx_pkg::PHASE_OPCODE;
         is_read_ff <= 1'b0;
         addr_ff    <= gpx_pkg::ADDR_EMPTY;
         dir_a_ff   <= gpx_pkg::DIR_RESET;
         dir_b_ff   <= gpx_pkg::DIR_RESET;
         pol_a_ff   <= '0;
         pol_b_ff   <= '0;
         pu_a_ff    <= '0;
         pu_b_ff    <= '0;
         drv_a_ff   <= '0;
         drv_b_ff   <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         is_read_ff <= is_read_in;
         addr_ff    <= addr_in;
         dir_a_ff   <= dir_a_in;
         dir_b_ff   <= dir_b_in;
         pol_a_ff   <= pol_a_in;
         pol_b_ff   <= pol_b_in;
         pu_a_ff    <= pu_a_in;
         pu_b_ff    <= pu_b_in;
         drv_a_ff   <= drv_a_in;
         drv_b_ff   <= drv_b_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      is_read_in = is_read_ff;
      addr_in    = addr_ff;
      dir_a_in   = dir_a_ff;
      dir_b_in   = dir_b_ff;
      pol_a_in   = pol_a_ff;
      pol_b_in   = pol_b_ff;
      pu_a_in    = pu_a_ff;
      pu_b_in    = pu_b_ff;
      drv_a_in   = drv_a_ff;
      drv_b_in   = drv_b_ff;
      rf_clear   = 1'b0;
      rf_rd_en   = 1'b0;
      rf_rd_idx  = spi_byte[IDX_W-1:0];
      rf_wr_en   = 1'b0;
      rf_wr_idx  = addr_ff[IDX_W-1:0];
      rf_wr_data = spi_byte;
      info.use_mem = 1'b0;
      info.miso    = spi_byte;

      if (command == gpx_pkg::CMD_RESET) begin
         // drive latch survives the reset pin
         phase_in   = gpx_pkg::PHASE_OPCODE;
         is_read_in = 1'b0;
         addr_in    = gpx_pkg::ADDR_EMPTY;
         dir_a_in   = gpx_pkg::DIR_RESET;
         dir_b_in   = gpx_pkg::DIR_RESET;
         pol_a_in   = '0;
         pol_b_in   = '0;
         pu_a_in    = '0;
         pu_b_in    = '0;
         rf_clear   = accept;
         info.miso  = '0;
      end else begin
         case (phase_ff)
            gpx_pkg::PHASE_ADDRESS: begin
               addr_in = spi_byte;
               if (is_read_ff) begin
                  phase_in = gpx_pkg::PHASE_OPCODE;
                  if (spi_byte == gpx_pkg::ADDR_GPIO_A) begin
                     info.miso = pin_levels_a ^ (dir_a_ff & pol_a_ff);
                  end else if (spi_byte == gpx_pkg::ADDR_GPIO_B) begin
                     info.miso = pin_levels_b ^ (dir_b_ff & pol_b_ff);
                  end else if (spi_byte < COUNT) begin
                     rf_rd_en     = accept;
                     info.use_mem = 1'b1;
                  end else begin
                     info.miso = '0;
                  end
               end else begin
                  phase_in = gpx_pkg::PHASE_DATA;
               end
            end
            gpx_pkg::PHASE_DATA: begin
               phase_in = gpx_pkg::PHASE_OPCODE;
               if (addr_ff < COUNT) begin
                  rf_wr_en = accept;
                  // the gpio entry itself is never read back, only its latch copy
                  if (addr_ff == gpx_pkg::ADDR_GPIO_A) begin
                     rf_wr_idx = IDX_W'(gpx_pkg::ADDR_OLAT_A);
                     drv_a_in  = (drv_a_ff & dir_a_ff) | (spi_byte & ~dir_a_ff);
                  end else if (addr_ff == gpx_pkg::ADDR_GPIO_B) begin
                     rf_wr_idx = IDX_W'(gpx_pkg::ADDR_OLAT_B);
                     drv_b_in  = (drv_b_ff & dir_b_ff) | (spi_byte & ~dir_b_ff);
                  end
                  if (addr_ff == gpx_pkg::ADDR_DIR_A) dir_a_in = spi_byte;
                  if (addr_ff == gpx_pkg::ADDR_DIR_B) dir_b_in = spi_byte;
                  if (addr_ff == gpx_pkg::ADDR_POL_A) pol_a_in = spi_byte;
                  if (addr_ff == gpx_pkg::ADDR_POL_B) pol_b_in = spi_byte;
                  if (addr_ff == gpx_pkg::ADDR_PU_A)  pu_a_in  = spi_byte;
                  if (addr_ff == gpx_pkg::ADDR_PU_B)  pu_b_in  = spi_byte;
               end
            end
            default: begin
               phase_in = gpx_pkg::PHASE_OPCODE;
               if (spi_byte == gpx_pkg::OP_WRITE || spi_byte == gpx_pkg::OP_READ) begin
                  is_read_in = (spi_byte == gpx_pkg::OP_READ);
                  phase_in   = gpx_pkg::PHASE_ADDRESS;
               end
            end
         endcase
      end

      info.drive_a  = drv_a_in;
      info.drive_b  = drv_b_in;
      info.enable_a = ~dir_a_in;
      info.enable_b = ~dir_b_in;
      info.pullup_a = dir_a_in & pu_a_in;
      info.pullup_b = dir_b_in & pu_b_in;
   end

endmodule

`default_nettype wire

@@ rtl/spi_gpio_expander_registers_top.sv @@
// top level of the spi gpio expander register block
// instantiates gpx_tracker and gpx_regfile; uses gpx_pkg
//
// usage
//   req channel: one transfer per received spi byte or reset pin event.
//     req_tuser = 0 carries a byte, 1 a reset event (byte ignored).
//     req_tdata holds the byte and the sampled levels of both ports.
//   rsp channel: exactly one transfer per request, in order: the next miso
//     byte and the pin controls (drive, output enable, pull-up) for both ports.
//   a result is offered the cycle after its request transfer.
//   throughput: one item per cycle while rsp_tready is high; the single
//     read port of the register file is read in the request cycle and its
//     registered data feeds the result directly. a write lands at its own
//     transfer edge, so a read in the very next item already sees it.
//   stall: the result register holds while rsp_tready is low, and
//     req_tready follows it, so one item is in flight at most.
//   reset: clears the command tracker, pin control registers, drive latch
//     and the register file valid bits; no clearing pass is needed.
//   a reset event through the channel restores the register file but keeps
//     the drive latch.
`default_nettype none

module spi_gpio_expander_registers_top #(
   parameter int REGISTER_COUNT = 22
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // spi_byte, pin_levels_a, pin_levels_b
   input  wire logic        req_tuser,   // command
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [55:0] rsp_tdata    // miso_byte, drive_a, drive_b, enable_a,
                                         // enable_b, pullup_a, pullup_b
);

   localparam int IDX_W = $clog2(REGISTER_COUNT);

   logic                  accept;
   logic                  rf_clear;
   logic                  rf_rd_en;
   logic [IDX_W-1:0]      rf_rd_idx;
   logic                  rf_wr_en;
   logic [IDX_W-1:0]      rf_wr_idx;
   logic [7:0]            rf_wr_data;
   logic [7:0]            rf_rd_data;
   gpx_pkg::rsp_info_type info;
   gpx_pkg::rsp_info_type rsp_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            miso;

   // take a new item whenever the result register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   gpx_tracker #(
      .REGISTER_COUNT(REGISTER_COUNT),
      .IDX_W(IDX_W)
   ) u_tracker (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .command(req_tuser),
      .spi_byte(req_tdata[7:0]),
      .pin_levels_a(req_tdata[15:8]),
      .pin_levels_b(req_tdata[23:16]),
      .rf_clear(rf_clear),
      .rf_rd_en(rf_rd_en),
      .rf_rd_idx(rf_rd_idx),
      .rf_wr_en(rf_wr_en),
      .rf_wr_idx(rf_wr_idx),
      .rf_wr_data(rf_wr_data),
      .info(info)
   );

   gpx_regfile #(
      .REGISTER_COUNT(REGISTER_COUNT),
      .IDX_W(IDX_W)
   ) u_regfile (
      .clock(clock),
      .reset(reset),
      .clear(rf_clear),
      .rd_en(rf_rd_en),
      .rd_idx(rf_rd_idx),
      .wr_en(rf_wr_en),
      .wr_idx(rf_wr_idx),
      .wr_data(rf_wr_data),
      .rd_data(rf_rd_data)
   );

   // result register; read data of the register file pairs with it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= info;
      end
   end

   // memory read data only changes on a request transfer, so it holds under stall
   assign miso = rsp_ff.use_mem ? rf_rd_data : rsp_ff.miso;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.pullup_b, rsp_ff.pullup_a, rsp_ff.enable_b, rsp_ff.enable_a,
                        rsp_ff.drive_b, rsp_ff.drive_a, miso};

endmodule

`default_nettype wire
